/* sv/ips_prd_pkg.sv */
// Shared types and constants for the IPS patch record decoder.
// Holds result kinds, error codes, the result struct and the magic/EOF text lookups.
// No dependencies.
package ips_prd_pkg;

  localparam int unsigned AddrW  = 24;
  localparam int unsigned DataW  = 8;
  localparam int unsigned RunW   = 16;
  localparam int unsigned IdxW   = 3;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_MAGIC     = 2'd1,
    ERR_NORECORDS = 2'd2,
    ERR_TRUNCATED = 2'd3
  } err_e;

  typedef struct packed {
    kind_e             kind;
    logic [AddrW-1:0]  target_address;
    logic [DataW-1:0]  data_value;
    logic [RunW-1:0]   run_length;
    err_e              error_code;
  } result_t;

  localparam int unsigned MagicLen = 5;
  localparam logic [IdxW-1:0] MagicLast = IdxW'(MagicLen - 1);

  // Character of "PATCH" at a given position.
  function automatic logic [DataW-1:0] magic_char(logic [IdxW-1:0] idx);
    logic [DataW-1:0] ch;
    case (idx)
      3'd0:    ch = 8'h50;
      3'd1:    ch = 8'h41;
      3'd2:    ch = 8'h54;
      3'd3:    ch = 8'h43;
      3'd4:    ch = 8'h48;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Character of "EOF" at a given position.
  function automatic logic [DataW-1:0] eof_char(logic [1:0] idx);
    logic [DataW-1:0] ch;
    case (idx)
      2'd0:    ch = 8'h45;
      2'd1:    ch = 8'h4F;
      2'd2:    ch = 8'h46;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* sv/ips_patch_record_decoder_core.sv */
// IPS patch record decoder: one patch byte per cycle in while ready, write/fill/finish/error beats out.
// Each result is registered in the output stage before it leaves; under back-pressure it waits in the skid stage.
// Throughput: one input beat per cycle while in_ready_o is high.
// Ready drops only while the skid stage holds a second unread result.
// Reset (rst_ni, async, active low): parser returns to the magic check, output stage empties.
// Depends on ips_prd_pkg, ips_prd_parser, ips_prd_skid.
module ips_patch_record_decoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [ips_prd_pkg::DataW-1:0] patch_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    kind_o,
  output logic [ips_prd_pkg::AddrW-1:0] target_address_o,
  output logic [ips_prd_pkg::DataW-1:0] data_value_o,
  output logic [ips_prd_pkg::RunW-1:0]  run_length_o,
  output logic [1:0]                    error_code_o
);

  logic                 space;
  logic                 beat;
  logic                 res_valid;
  ips_prd_pkg::result_t res;
  ips_prd_pkg::result_t out_data;

  // Accept a beat whenever the output stage can absorb one more result.
  assign in_ready_o = space;
  assign beat       = in_valid_i && space;

  // Advance the parse state and form at most one result per beat.
  ips_prd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (beat),
    .opcode_i     (opcode_i),
    .patch_byte_i (patch_byte_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Hold results in the output register, spill into the skid stage on stall.
  ips_prd_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign kind_o           = out_data.kind;
  assign target_address_o = out_data.target_address;
  assign data_value_o     = out_data.data_value;
  assign run_length_o     = out_data.run_length;
  assign error_code_o     = out_data.error_code;

endmodule

/* sv/ips_prd_parser.sv */
// Record parser for the IPS patch decoder: parse state registers and next-state logic.
// Produces at most one result per accepted beat, combinationally from the current state and the beat.
// Depends on ips_prd_pkg.
module ips_prd_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          beat_i,
  input  logic                          opcode_i,
  input  logic [ips_prd_pkg::DataW-1:0] patch_byte_i,
  output logic                          res_valid_o,
  output ips_prd_pkg::result_t          res_o
);

  typedef enum logic [7:0] {
    PH_MAGIC  = 8'b0000_0001,
    PH_OFFSET = 8'b0000_0010,
    PH_SIZE   = 8'b0000_0100,
    PH_DATA   = 8'b0000_1000,
    PH_COUNT  = 8'b0001_0000,
    PH_VALUE  = 8'b0010_0000,
    PH_DONE   = 8'b0100_0000,
    PH_ERROR  = 8'b1000_0000
  } phase_e;

  phase_e                              phase_q, phase_d;
  logic [ips_prd_pkg::IdxW-1:0]        idx_q, idx_d;
  logic [ips_prd_pkg::AddrW-1:0]       offset_q, offset_d;
  logic [ips_prd_pkg::RunW-1:0]        size_q, size_d;
  logic [ips_prd_pkg::RunW-1:0]        rem_q, rem_d;
  logic                                seen_q, seen_d;
  logic [1:0]                          eof_q, eof_d;
  logic [1:0]                          oidx;
  logic                                res_valid;
  ips_prd_pkg::result_t                res;

  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    offset_d  = offset_q;
    size_d    = size_q;
    rem_d     = rem_q;
    seen_d    = seen_q;
    eof_d     = eof_q;
    res_valid = 1'b0;
    res       = '{kind: ips_prd_pkg::KIND_WRITE, error_code: ips_prd_pkg::ERR_NONE,
                  default: '0};
    oidx      = (idx_q > 3'd2) ? 2'd2 : idx_q[1:0];

    if (beat_i && phase_q != PH_DONE && phase_q != PH_ERROR) begin
      if (opcode_i == ips_prd_pkg::OP_END) begin
        phase_d        = PH_ERROR;
        res_valid      = 1'b1;
        res.kind       = ips_prd_pkg::KIND_ERROR;
        res.error_code = ips_prd_pkg::ERR_TRUNCATED;
      end else begin
        unique case (phase_q)
          PH_MAGIC: begin
            if (idx_q > ips_prd_pkg::MagicLast ||
                patch_byte_i != ips_prd_pkg::magic_char(idx_q)) begin
              phase_d        = PH_ERROR;
              res_valid      = 1'b1;
              res.kind       = ips_prd_pkg::KIND_ERROR;
              res.error_code = ips_prd_pkg::ERR_MAGIC;
            end else if (idx_q == ips_prd_pkg::MagicLast) begin
              phase_d  = PH_OFFSET;
              idx_d    = '0;
              offset_d = '0;
              eof_d    = '0;
            end else begin
              idx_d = idx_q + 3'd1;
            end
          end
          PH_OFFSET: begin
            if (eof_q == oidx && patch_byte_i == ips_prd_pkg::eof_char(oidx)) begin
              eof_d = oidx + 2'd1;
            end
            offset_d = {offset_q[15:0], patch_byte_i};
            if (oidx < 2'd2) begin
              idx_d = {1'b0, oidx} + 3'd1;
            end else begin
              idx_d = '0;
              if (eof_d == 2'd3) begin
                res_valid = 1'b1;
                if (!seen_q) begin
                  phase_d        = PH_ERROR;
                  res.kind       = ips_prd_pkg::KIND_ERROR;
                  res.error_code = ips_prd_pkg::ERR_NORECORDS;
                end else begin
                  phase_d  = PH_DONE;
                  res.kind = ips_prd_pkg::KIND_DONE;
                end
              end else begin
                seen_d  = 1'b1;
                size_d  = '0;
                phase_d = PH_SIZE;
              end
            end
          end
          PH_SIZE: begin
            size_d = {size_q[7:0], patch_byte_i};
            if (idx_q == 3'd0) begin
              idx_d = 3'd1;
            end else begin
              idx_d = '0;
              if (size_d == '0) begin
                rem_d   = '0;
                phase_d = PH_COUNT;
              end else begin
                rem_d   = size_d;
                phase_d = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            res_valid          = 1'b1;
            res.kind           = ips_prd_pkg::KIND_WRITE;
            res.target_address = offset_q;
            res.data_value     = patch_byte_i;
            res.run_length     = 16'd1;
            offset_d           = offset_q + 24'd1;
            rem_d              = rem_q - 16'd1;
            if (rem_d == '0) begin
              phase_d  = PH_OFFSET;
              idx_d    = '0;
              eof_d    = '0;
              offset_d = '0;
            end
          end
          PH_COUNT: begin
            rem_d = {rem_q[7:0], patch_byte_i};
            if (idx_q == 3'd0) begin
              idx_d = 3'd1;
            end else begin
              idx_d   = '0;
              phase_d = PH_VALUE;
            end
          end
          PH_VALUE: begin
            phase_d  = PH_OFFSET;
            idx_d    = '0;
            eof_d    = '0;
            offset_d = '0;
            rem_d    = '0;
            if (rem_q != '0) begin
              res_valid          = 1'b1;
              res.kind           = ips_prd_pkg::KIND_FILL;
              res.target_address = offset_q;
              res.data_value     = patch_byte_i;
              res.run_length     = rem_q;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAGIC;
      idx_q    <= '0;
      offset_q <= '0;
      size_q   <= '0;
      rem_q    <= '0;
      seen_q   <= 1'b0;
      eof_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      offset_q <= offset_d;
      size_q   <= size_d;
      rem_q    <= rem_d;
      seen_q   <= seen_d;
      eof_q    <= eof_d;
    end
  end

  assign res_valid_o = res_valid;
  assign res_o       = res;

endmodule

/* sv/ips_prd_skid.sv */
// Result register with a one-entry skid stage for the IPS patch decoder.
// Parts the input side from output back-pressure. Depends on ips_prd_pkg.
module ips_prd_skid (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ips_prd_pkg::result_t push_data_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ips_prd_pkg::result_t out_data_o
);

  logic                 main_valid_q;
  logic                 skid_valid_q;
  ips_prd_pkg::result_t main_q;
  ips_prd_pkg::result_t skid_q;
  logic                 take;

  assign take = main_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || take) begin
        main_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (take) begin
      main_valid_q <= 1'b0;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (!main_valid_q || take) begin
        main_q <= push_data_i;
      end else begin
        skid_q <= push_data_i;
      end
    end
  end

  assign space_o     = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

endmodule

/* test/patch_decode_checker.sv */
// Watches both channels of the IPS patch record decoder, predicts each result and compares it.
// Depends on ips_prd_pkg for the result struct, kinds, error codes and opcodes.
module patch_decode_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          opcode_i,
  input  logic [ips_prd_pkg::DataW-1:0] patch_byte_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [1:0]                    kind_i,
  input  logic [ips_prd_pkg::AddrW-1:0] target_address_i,
  input  logic [ips_prd_pkg::DataW-1:0] data_value_i,
  input  logic [ips_prd_pkg::RunW-1:0]  run_length_i,
  input  logic [1:0]                    error_code_i,
  output int unsigned                   pending_o,
  output int unsigned                   failures_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ips_prd_pkg::*;

  typedef enum logic [3:0] {
    P_MAGIC, P_OFFSET, P_SIZE, P_DATA, P_COUNT, P_VALUE, P_DONE, P_ERROR
  } parse_phase_e;

  localparam logic [39:0] MagicText = "PATCH";
  localparam logic [23:0] EofText   = "EOF";

  parse_phase_e     phase;
  logic [2:0]       byte_pos;
  logic [AddrW-1:0] offset;
  logic [RunW-1:0]  size;
  logic [RunW-1:0]  remaining;
  logic             seen_record;
  logic [1:0]       eof_hits;

  result_t     pending_results[$];
  result_t     want;
  int unsigned mismatch_count;

  initial begin
    mismatch_count = 0;
  end

  function automatic void queue_result(kind_e k, logic [AddrW-1:0] addr, logic [DataW-1:0] data,
                                       logic [RunW-1:0] run, err_e err);
    result_t r;
    r.kind           = k;
    r.target_address = addr;
    r.data_value     = data;
    r.run_length     = run;
    r.error_code     = err;
    pending_results.push_back(r);
  endfunction

  function automatic void flag_error(err_e err);
    phase = P_ERROR;
    queue_result(KIND_ERROR, '0, '0, '0, err);
  endfunction

  // Advance the parse state by one accepted beat.
  function automatic void decode_patch_beat(logic op, logic [DataW-1:0] b);
    logic [2:0]       idx;
    logic [AddrW-1:0] addr;
    logic [RunW-1:0]  count;
    idx = byte_pos;
    if (phase == P_DONE || phase == P_ERROR || phase > P_VALUE) return;
    if (op == OP_END) begin
      flag_error(ERR_TRUNCATED);
      return;
    end
    case (phase)
      P_MAGIC: begin
        if (idx > MagicLast || b != MagicText[8*(4-int'(idx)) +: 8]) begin
          flag_error(ERR_MAGIC);
        end else if (idx == MagicLast) begin
          phase    = P_OFFSET;
          byte_pos = '0;
          offset   = '0;
          eof_hits = '0;
        end else begin
          byte_pos = idx + 3'd1;
        end
      end
      P_OFFSET: begin
        if (idx > 3'd2) idx = 3'd2;
        if (eof_hits == idx[1:0] && b == EofText[8*(2-int'(idx)) +: 8]) begin
          eof_hits = idx[1:0] + 2'd1;
        end
        offset = {offset[15:0], b};
        if (idx < 3'd2) begin
          byte_pos = idx + 3'd1;
        end else begin
          byte_pos = '0;
          if (eof_hits == 2'd3) begin
            if (!seen_record) begin
              flag_error(ERR_NORECORDS);
            end else begin
              phase = P_DONE;
              queue_result(KIND_DONE, '0, '0, '0, ERR_NONE);
            end
          end else begin
            seen_record = 1'b1;
            size        = '0;
            phase       = P_SIZE;
          end
        end
      end
      P_SIZE: begin
        size = {size[7:0], b};
        if (idx == 3'd0) begin
          byte_pos = 3'd1;
        end else begin
          byte_pos  = '0;
          remaining = size;
          phase     = (size == '0) ? P_COUNT : P_DATA;
        end
      end
      P_DATA: begin
        addr      = offset;
        offset    = offset + 1'b1;
        remaining = remaining - 1'b1;
        if (remaining == '0) begin
          phase    = P_OFFSET;
          byte_pos = '0;
          eof_hits = '0;
          offset   = '0;
        end
        queue_result(KIND_WRITE, addr, b, RunW'(1), ERR_NONE);
      end
      P_COUNT: begin
        remaining = {remaining[7:0], b};
        if (idx == 3'd0) begin
          byte_pos = 3'd1;
        end else begin
          byte_pos = '0;
          phase    = P_VALUE;
        end
      end
      default: begin
        addr      = offset;
        count     = remaining;
        phase     = P_OFFSET;
        byte_pos  = '0;
        eof_hits  = '0;
        offset    = '0;
        remaining = '0;
        if (count != '0) queue_result(KIND_FILL, addr, b, count, ERR_NONE);
      end
    endcase
  endfunction

  function automatic void check_field(string field, logic [AddrW-1:0] exp_v,
                                      logic [AddrW-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", field, exp_v, got_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase       = P_MAGIC;
      byte_pos    = '0;
      offset      = '0;
      size        = '0;
      remaining   = '0;
      seen_record = 1'b0;
      eof_hits    = '0;
      pending_results.delete();
    end else begin
      // Compare first: a result never leaves in the cycle of the beat that causes it.
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected: kind %0d addr %0h", kind_i,
                 target_address_i);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", want.kind, kind_i);
          check_field("target_address", want.target_address, target_address_i);
          check_field("data_value", want.data_value, data_value_i);
          check_field("run_length", want.run_length, run_length_i);
          check_field("error_code", want.error_code, error_code_i);
        end
      end
      if (in_valid_i && in_ready_i) decode_patch_beat(opcode_i, patch_byte_i);
    end
    pending_o  <= pending_results.size();
    failures_o <= mismatch_count;
  end

endmodule

/* test/tb_top.sv */
// Top of the IPS patch record decoder testbench: clock, reset, patch stream stimulus, verdict.
// Depends on ips_prd_pkg, ips_patch_record_decoder_core and patch_decode_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ips_prd_pkg::*;

  localparam logic [39:0] MagicText   = "PATCH";
  localparam logic [23:0] EofText     = "EOF";
  localparam int unsigned ItemTarget  = 800;
  // Drop all idling for the last stretch of the stream.
  localparam int unsigned QuietAfter  = 700;
  localparam int unsigned DrainCycles = 20;

  logic clk;
  logic rst_n = 1'b0;

  logic             in_valid   = 1'b0;
  logic             opcode     = OP_BYTE;
  logic [DataW-1:0] patch_byte = '0;
  logic             out_ready  = 1'b0;

  logic             in_ready;
  logic             out_valid;
  logic [1:0]       kind;
  logic [AddrW-1:0] target_address;
  logic [DataW-1:0] data_value;
  logic [RunW-1:0]  run_length;
  logic [1:0]       error_code;

  int unsigned pending;
  int unsigned failures;

  int unsigned beats_sent = 0;
  bit          idling_on  = 1'b1;

  // Bytes of the record(s) staged for the next send.
  logic [DataW-1:0] record_bytes[$];

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  ips_patch_record_decoder_core dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .opcode_i         (opcode),
    .patch_byte_i     (patch_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .kind_o           (kind),
    .target_address_o (target_address),
    .data_value_o     (data_value),
    .run_length_o     (run_length),
    .error_code_o     (error_code)
  );

  patch_decode_checker checker_u (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .opcode_i         (opcode),
    .patch_byte_i     (patch_byte),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .kind_i           (kind),
    .target_address_i (target_address),
    .data_value_i     (data_value),
    .run_length_i     (run_length),
    .error_code_i     (error_code),
    .pending_o        (pending),
    .failures_o       (failures)
  );

  // Offset bytes go out big-endian, as do the 16-bit size and count fields.
  function automatic void put_offset(logic [AddrW-1:0] ofs);
    record_bytes.push_back(ofs[23:16]);
    record_bytes.push_back(ofs[15:8]);
    record_bytes.push_back(ofs[7:0]);
  endfunction

  function automatic void put_half(logic [RunW-1:0] h);
    record_bytes.push_back(h[15:8]);
    record_bytes.push_back(h[7:0]);
  endfunction

  // A fill record: zero size, then count and value.
  function automatic void add_fill_record(logic [AddrW-1:0] ofs, logic [RunW-1:0] count,
                                          logic [DataW-1:0] value);
    put_offset(ofs);
    put_half('0);
    put_half(count);
    record_bytes.push_back(value);
  endfunction

  // One well-formed record with random content. Offsets lean toward the top of the
  // address space (wrap) and toward partial "EOF" prefixes; a full "EOF" is avoided.
  function automatic void add_random_record();
    logic [AddrW-1:0] ofs;
    logic [RunW-1:0]  count;
    int unsigned      len;
    case ($urandom_range(0, 9))
      0:       ofs = {EofText[23:8], 8'($urandom)};
      1:       ofs = {EofText[23:16], 16'($urandom)};
      2:       ofs = {16'hFFFF, 8'($urandom)};
      3:       ofs = '0;
      default: ofs = 24'($urandom);
    endcase
    if (ofs == EofText) ofs[0] = ~ofs[0];
    if ($urandom_range(0, 9) < 7) begin
      // Mostly short writes, now and then a long one.
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 200) : $urandom_range(1, 8);
      put_offset(ofs);
      put_half(RunW'(len));
      repeat (len) record_bytes.push_back(8'($urandom));
    end else begin
      case ($urandom_range(0, 5))
        0:       count = '0;
        1:       count = '1;
        2:       count = RunW'(1);
        default: count = 16'($urandom);
      endcase
      add_fill_record(ofs, count, 8'($urandom));
    end
  endfunction

  // Drive one beat; hold valid and payload until accepted. Random gaps before the beat.
  task automatic send_beat(input logic op, input logic [DataW-1:0] value);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    patch_byte <= value;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (beats_sent >= QuietAfter) idling_on = 1'b0;
  endtask

  // Send the first keep staged bytes, then drop the rest.
  task automatic send_record_bytes(input int unsigned keep);
    for (int unsigned i = 0; i < keep; i++) send_beat(OP_BYTE, record_bytes[i]);
    record_bytes.delete();
  endtask

  // Result side: random stall bursts, off once the quiet tail starts.
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (idling_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    bit          paused;
    int unsigned cut;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: magic, a write record that wraps past the top address with data
    // extremes, a zero-count fill at an offset sharing the "EO" prefix, and a
    // full-length fill.
    for (int i = 0; i < 5; i++) send_beat(OP_BYTE, MagicText[8*(4-i) +: 8]);
    put_offset('1);
    put_half(RunW'(2));
    record_bytes.push_back('0);
    record_bytes.push_back('1);
    add_fill_record({EofText[23:8], 8'h58}, '0, '1);
    add_fill_record('0, '1, '0);
    send_record_bytes(record_bytes.size());

    // Random: a long well-formed record list.
    while (beats_sent < ItemTarget) begin
      if (!paused && beats_sent >= ItemTarget / 2) begin
        // Hold off the sender until every result so far has come back.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        paused = 1'b1;
      end
      add_random_record();
      send_record_bytes(record_bytes.size());
    end

    // Close the patch: either the EOF marker or an end of input part way into a record.
    if ($urandom_range(0, 2) != 0) begin
      put_offset(EofText);
      send_record_bytes(record_bytes.size());
    end else begin
      add_random_record();
      cut = $urandom_range(0, record_bytes.size() - 1);
      send_record_bytes(cut);
      send_beat(OP_END, 8'($urandom));
    end

    // The block is finished now; these beats must produce nothing.
    send_beat(OP_END, 8'($urandom));
    repeat (5) send_beat(1'($urandom), 8'($urandom));
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
sv/ips_prd_pkg.sv
sv/ips_prd_parser.sv
sv/ips_prd_skid.sv
sv/ips_patch_record_decoder_core.sv
test/patch_decode_checker.sv
test/tb_top.sv
